>>> hdl/gnd_pkg.sv
package gnd_pkg;

   // field widths
   localparam int NoteKinds   = 8;
   localparam int AmountWidth = 18;
   localparam int CountWidth  = 14;
   localparam int ValueWidth  = 10;

   // note values, largest first, and the inventory after reset
   localparam logic [ValueWidth-1:0] NOTE_VALUE [NoteKinds] = '{
      10'd500, 10'd150, 10'd50, 10'd20, 10'd10, 10'd5, 10'd2, 10'd1
   };
   localparam logic [CountWidth-1:0] NOTE_RESET [NoteKinds] = '{
      14'd100, 14'd200, 14'd400, 14'd800, 14'd1600, 14'd3200, 14'd6400, 14'd12800
   };

   typedef logic [CountWidth-1:0] count_type;

   // result status codes
   typedef enum logic [1:0] {
      ST_PAID       = 2'd0,
      ST_NO_BALANCE = 2'd1,
      ST_UNFORMABLE = 2'd2
   } status_type;

   // controller states
   typedef enum logic [1:0] {
      S_IDLE,
      S_RUN,
      S_DONE
   } state_type;

   // what one cell hands to the next: remainder still to pay and value seen so far
   typedef struct packed {
      logic                   valid;
      logic [AmountWidth-1:0] rem;
      logic [AmountWidth-1:0] sum;
   } token_type;

endpackage

>>> hdl/gnd_cell.sv
module gnd_cell #(
   parameter int Kind = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  gnd_pkg::token_type   token_in,
   input  logic                 commit,
   output gnd_pkg::token_type   token_out,
   output gnd_pkg::count_type   take
);

   localparam int AmountWidth = gnd_pkg::AmountWidth;
   localparam int CountWidth  = gnd_pkg::CountWidth;
   localparam int ValueWidth  = gnd_pkg::ValueWidth;
   localparam logic [ValueWidth-1:0] Value = gnd_pkg::NOTE_VALUE[Kind];
   // exact floor division of an 18-bit value by a reciprocal multiply
   localparam int Shift      = AmountWidth + $clog2(int'(Value));
   localparam int RecipWidth = AmountWidth + 1;
   localparam int ProdWidth  = AmountWidth + RecipWidth;
   localparam int PayWidth   = CountWidth + ValueWidth;
   localparam logic [RecipWidth-1:0] Recip =
      RecipWidth'(((64'd1 << Shift) + 64'(Value) - 64'd1) / 64'(Value));

   logic [ProdWidth-1:0]   prod;
   logic [AmountWidth-1:0] quot_in;
   logic                   va_ff;
   logic [AmountWidth-1:0] quot_ff;
   logic [AmountWidth-1:0] rem_a_ff;
   logic [AmountWidth-1:0] sum_a_ff;
   gnd_pkg::count_type     take_in;
   logic [PayWidth-1:0]    pay;
   logic [PayWidth-1:0]    held;
   logic [AmountWidth-1:0] rem_in;
   logic [AmountWidth-1:0] sum_in;
   logic                   vb_ff;
   logic [AmountWidth-1:0] rem_b_ff;
   logic [AmountWidth-1:0] sum_b_ff;
   gnd_pkg::count_type     take_ff;
   gnd_pkg::count_type     inv_in;
   gnd_pkg::count_type     inv_ff;

   // stage a: notes wanted = remainder / value
   assign prod    = ProdWidth'(token_in.rem) * ProdWidth'(Recip);
   assign quot_in = AmountWidth'(prod >> Shift);

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
      end else begin
         va_ff <= token_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (token_in.valid) begin
         quot_ff  <= quot_in;
         rem_a_ff <= token_in.rem;
         sum_a_ff <= token_in.sum;
      end
   end

   // stage b: limit by inventory, pay out, add this kind's held value
   always_comb begin
      take_in = (quot_ff > AmountWidth'(inv_ff)) ? inv_ff : quot_ff[CountWidth-1:0];
      pay     = PayWidth'(take_in) * PayWidth'(Value);
      held    = PayWidth'(inv_ff) * PayWidth'(Value);
      rem_in  = rem_a_ff - AmountWidth'(pay);
      sum_in  = sum_a_ff + AmountWidth'(held);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vb_ff <= 1'b0;
      end else begin
         vb_ff <= va_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (va_ff) begin
         rem_b_ff <= rem_in;
         sum_b_ff <= sum_in;
         take_ff  <= take_in;
      end
   end

   // inventory drops by the last take when the payout commits
   assign inv_in = commit ? (inv_ff - take_ff) : inv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         inv_ff <= gnd_pkg::NOTE_RESET[Kind];
      end else begin
         inv_ff <= inv_in;
      end
   end

   assign token_out.valid = vb_ff;
   assign token_out.rem   = rem_b_ff;
   assign token_out.sum   = sum_b_ff;
   assign take            = take_ff;

endmodule

>>> hdl/greedy_note_dispenser_core.sv
// one item at a time: a new item is accepted only in the idle state, which the core
// enters once the previous result has moved into the output register
// each item passes a chain of eight note cells, two stages per cell
// a finished result waits in the output register while the core goes idle
// reset (synchronous, active high) restores the inventory to its initial counts
module greedy_note_dispenser_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [17:0] req_amount,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [13:0] rsp_notes_500,
   output logic [13:0] rsp_notes_150,
   output logic [13:0] rsp_notes_50,
   output logic [13:0] rsp_notes_20,
   output logic [13:0] rsp_notes_10,
   output logic [13:0] rsp_notes_5,
   output logic [13:0] rsp_notes_2,
   output logic [13:0] rsp_notes_1
);

   localparam int NoteKinds   = gnd_pkg::NoteKinds;
   localparam int AmountWidth = gnd_pkg::AmountWidth;

   gnd_pkg::state_type     state_ff;
   gnd_pkg::state_type     state_in;
   gnd_pkg::token_type     launch_ff;
   gnd_pkg::token_type     launch_in;
   gnd_pkg::token_type     link [NoteKinds+1];
   gnd_pkg::token_type     chain_end;
   gnd_pkg::count_type     take [NoteKinds];
   gnd_pkg::count_type     notes_ff [NoteKinds];
   gnd_pkg::status_type    verdict;
   gnd_pkg::status_type    status_ff;
   logic [AmountWidth-1:0] amount_ff;
   logic                   accept;
   logic                   slot_free;
   logic                   finish;
   logic                   commit;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;

   // chain of note cells, largest value first
   assign link[0] = launch_ff;

   for (genvar k = 0; k < NoteKinds; k++) begin : g_cell
      gnd_cell #(
         .Kind(k)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .token_in (link[k]),
         .commit   (commit),
         .token_out(link[k+1]),
         .take     (take[k])
      );
   end

   assign chain_end = link[NoteKinds];

   // outcome of the item at the end of the chain
   always_comb begin
      if (amount_ff > chain_end.sum) begin
         verdict = gnd_pkg::ST_NO_BALANCE;
      end else if (chain_end.rem != '0) begin
         verdict = gnd_pkg::ST_UNFORMABLE;
      end else begin
         verdict = gnd_pkg::ST_PAID;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         gnd_pkg::S_IDLE: begin
            if (req_valid) begin
               state_in = gnd_pkg::S_RUN;
            end
         end
         gnd_pkg::S_RUN: begin
            if (chain_end.valid) begin
               state_in = gnd_pkg::S_DONE;
            end
         end
         gnd_pkg::S_DONE: begin
            if (slot_free) begin
               state_in = gnd_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = gnd_pkg::S_IDLE;
         end
      endcase
   end

   // controller outputs
   always_comb begin
      req_ready = 1'b0;
      finish    = 1'b0;
      case (state_ff)
         gnd_pkg::S_IDLE: begin
            req_ready = 1'b1;
         end
         gnd_pkg::S_DONE: begin
            finish = slot_free;
         end
         default: begin
            req_ready = 1'b0;
            finish    = 1'b0;
         end
      endcase
   end

   assign accept    = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign commit    = finish && (verdict == gnd_pkg::ST_PAID);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gnd_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // launch the item into the first cell
   always_comb begin
      launch_in.valid = accept;
      launch_in.rem   = req_amount;
      launch_in.sum   = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         launch_ff.valid <= 1'b0;
      end else begin
         launch_ff.valid <= launch_in.valid;
      end
      if (accept) begin
         launch_ff.rem <= launch_in.rem;
         launch_ff.sum <= launch_in.sum;
         amount_ff     <= req_amount;
      end
   end

   // output register
   assign rsp_valid_in = finish ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         status_ff <= verdict;
         for (int k = 0; k < NoteKinds; k++) begin
            notes_ff[k] <= (verdict == gnd_pkg::ST_PAID) ? take[k] : '0;
         end
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = status_ff;
   assign rsp_notes_500 = notes_ff[0];
   assign rsp_notes_150 = notes_ff[1];
   assign rsp_notes_50  = notes_ff[2];
   assign rsp_notes_20  = notes_ff[3];
   assign rsp_notes_10  = notes_ff[4];
   assign rsp_notes_5   = notes_ff[5];
   assign rsp_notes_2   = notes_ff[6];
   assign rsp_notes_1   = notes_ff[7];

   // an item leaves the chain only while the controller waits for it
   a_end_in_run: assert property (@(posedge clock) disable iff (reset)
      chain_end.valid |-> state_ff == gnd_pkg::S_RUN)
      else $error("item left the cell chain outside of run");

   // nothing is launched while idle
   a_idle_no_launch: assert property (@(posedge clock) disable iff (reset)
      state_ff == gnd_pkg::S_IDLE |-> !launch_ff.valid)
      else $error("item in flight while idle");

   // a commit always shows up as a paid result
   a_commit_paid: assert property (@(posedge clock) disable iff (reset)
      commit |=> rsp_valid && rsp_status == gnd_pkg::ST_PAID)
      else $error("inventory committed without a paid result");

endmodule

>>> sim/testbench.sv
module testbench;

   localparam int NoteKinds   = gnd_pkg::NoteKinds;
   localparam int AmountWidth = gnd_pkg::AmountWidth;
   localparam int CountWidth  = gnd_pkg::CountWidth;

   localparam int RandomItems = 1032;
   localparam int StallLimit  = 4000;
   localparam int DrainCycles = 40;
   localparam int AmountMax   = (1 << AmountWidth) - 1;

   // idle percentages per phase (sender, receiver)
   localparam int SendIdleFirst = 32;
   localparam int RecvIdleFirst = 54;
   localparam int SendIdleSecond = 54;
   localparam int RecvIdleSecond = 32;

   typedef logic [0:NoteKinds-1][CountWidth-1:0] note_counts_type;

   typedef struct packed {
      gnd_pkg::status_type status;
      note_counts_type     notes;
   } payout_type;

   typedef struct packed {
      logic [AmountWidth-1:0] amount;
      logic                   known;
      payout_type             want;
   } withdrawal_type;

   localparam note_counts_type NO_NOTES = '0;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [17:0] req_amount = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_status;
   logic [13:0] rsp_notes_500, rsp_notes_150, rsp_notes_50, rsp_notes_20;
   logic [13:0] rsp_notes_10, rsp_notes_5, rsp_notes_2, rsp_notes_1;

   // inventory as the testbench expects it, largest note first
   gnd_pkg::count_type vault [NoteKinds] = gnd_pkg::NOTE_RESET;
   payout_type pending_payouts [$];
   int         mismatches = 0;
   int         checked_payouts = 0;
   int         stall_cycles = 0;
   int         send_idle_pct = SendIdleFirst;
   int         recv_idle_pct = RecvIdleFirst;

   // directed withdrawals; known rows carry their payout, the rest use the predictor
   withdrawal_type directed_plan [18] = '{
      '{18'd262143, 1'b1, '{gnd_pkg::ST_NO_BALANCE, NO_NOTES}},
      '{18'd173601, 1'b1, '{gnd_pkg::ST_NO_BALANCE, NO_NOTES}},
      '{18'd0,      1'b1, '{gnd_pkg::ST_PAID, NO_NOTES}},
      '{18'd1,      1'b1, '{gnd_pkg::ST_PAID,
         {14'd0, 14'd0, 14'd0, 14'd0, 14'd0, 14'd0, 14'd0, 14'd1}}},
      '{18'd2,      1'b1, '{gnd_pkg::ST_PAID,
         {14'd0, 14'd0, 14'd0, 14'd0, 14'd0, 14'd0, 14'd1, 14'd0}}},
      '{18'd3,      1'b1, '{gnd_pkg::ST_PAID,
         {14'd0, 14'd0, 14'd0, 14'd0, 14'd0, 14'd0, 14'd1, 14'd1}}},
      '{18'd500,    1'b1, '{gnd_pkg::ST_PAID,
         {14'd1, 14'd0, 14'd0, 14'd0, 14'd0, 14'd0, 14'd0, 14'd0}}},
      '{18'd738,    1'b1, '{gnd_pkg::ST_PAID,
         {14'd1, 14'd1, 14'd1, 14'd1, 14'd1, 14'd1, 14'd1, 14'd1}}},
      '{18'd688,    1'b1, '{gnd_pkg::ST_PAID,
         {14'd1, 14'd1, 14'd0, 14'd1, 14'd1, 14'd1, 14'd1, 14'd1}}},
      '{18'd999,    1'b1, '{gnd_pkg::ST_PAID,
         {14'd1, 14'd3, 14'd0, 14'd2, 14'd0, 14'd1, 14'd2, 14'd0}}},
      '{18'd60000,  1'b0, '0},
      '{18'd150,    1'b0, '0},
      '{18'd50,     1'b0, '0},
      '{18'd20,     1'b0, '0},
      '{18'd10,     1'b0, '0},
      '{18'd5,      1'b0, '0},
      '{18'd7,      1'b0, '0},
      '{18'd174762, 1'b0, '0}
   };

   greedy_note_dispenser_core DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_amount    (req_amount),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_status    (rsp_status),
      .rsp_notes_500 (rsp_notes_500),
      .rsp_notes_150 (rsp_notes_150),
      .rsp_notes_50  (rsp_notes_50),
      .rsp_notes_20  (rsp_notes_20),
      .rsp_notes_10  (rsp_notes_10),
      .rsp_notes_5   (rsp_notes_5),
      .rsp_notes_2   (rsp_notes_2),
      .rsp_notes_1   (rsp_notes_1)
   );

   // clock, period 12
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // value held in the vault
   function automatic int unsigned vault_total();
      int unsigned sum;
      sum = 0;
      for (int k = 0; k < NoteKinds; k++) begin
         sum += int'(gnd_pkg::NOTE_VALUE[k]) * int'(vault[k]);
      end
      return sum;
   endfunction

   // greedy payout from the largest note down; commits only an exact payout
   task automatic dispense_notes(input logic [AmountWidth-1:0] amount,
                                 output payout_type outcome);
      int unsigned rest, held, wanted;
      outcome = '0;
      rest = 32'(amount);
      if (rest > vault_total()) begin
         outcome.status = gnd_pkg::ST_NO_BALANCE;
      end else begin
         for (int k = 0; k < NoteKinds; k++) begin
            held   = 32'(vault[k]);
            wanted = rest / int'(gnd_pkg::NOTE_VALUE[k]);
            outcome.notes[k] = CountWidth'((wanted < held) ? wanted : held);
            rest -= int'(outcome.notes[k]) * int'(gnd_pkg::NOTE_VALUE[k]);
         end
         if (rest == 0) begin
            outcome.status = gnd_pkg::ST_PAID;
            for (int k = 0; k < NoteKinds; k++) begin
               vault[k] = vault[k] - outcome.notes[k];
            end
         end else begin
            outcome = '0;
            outcome.status = gnd_pkg::ST_UNFORMABLE;
         end
      end
   endtask

   // random withdrawal, mostly small draws that slowly empty the vault
   function automatic logic [AmountWidth-1:0] pick_amount();
      int unsigned total, roll;
      total = vault_total();
      roll  = $urandom_range(99);
      if (roll < 46) begin
         return AmountWidth'($urandom_range(300, 1));
      end else if (roll < 71) begin
         return AmountWidth'($urandom_range(total / 64 + 1, 1));
      end else if (roll < 86 && total < AmountMax) begin
         return AmountWidth'($urandom_range(AmountMax, total + 1));
      end else if (roll < 99) begin
         return AmountWidth'($urandom_range(AmountMax, 0));
      end else begin
         return AmountWidth'(total / 4 + $urandom_range(total / 4, 0));
      end
   endfunction

   task automatic report_mismatch(input string what);
      $display("mismatch, result %0d: %s", checked_payouts, what);
      mismatches++;
   endtask

   // present one withdrawal, wait for it to be taken, record the expected payout
   task automatic send_withdrawal(input logic [AmountWidth-1:0] amount, input logic known,
                                  input payout_type want);
      payout_type predicted;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid  <= 1'b1;
      req_amount <= amount;
      do @(posedge clock); while (!req_ready);
      dispense_notes(amount, predicted);
      pending_payouts.push_back(known ? want : predicted);
   endtask

   // stimulus and end of run
   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      foreach (directed_plan[i]) begin
         send_withdrawal(directed_plan[i].amount, directed_plan[i].known, directed_plan[i].want);
      end
      for (int n = 0; n < RandomItems; n++) begin
         if (n == RandomItems / 3) begin
            send_idle_pct = SendIdleSecond;
            recv_idle_pct = RecvIdleSecond;
         end else if (n == 2 * RandomItems / 3) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         send_withdrawal(pick_amount(), 1'b0, '0);
      end
      req_valid <= 1'b0;
      while (pending_payouts.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // receiver stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // compare each taken result with the oldest expected payout
   always @(posedge clock) begin
      payout_type got, want;
      if (!reset && rsp_valid && rsp_ready) begin
         got.status = gnd_pkg::status_type'(rsp_status);
         got.notes  = {rsp_notes_500, rsp_notes_150, rsp_notes_50, rsp_notes_20,
                       rsp_notes_10, rsp_notes_5, rsp_notes_2, rsp_notes_1};
         if (pending_payouts.size() == 0) begin
            report_mismatch("result with no item outstanding");
         end else begin
            want = pending_payouts.pop_front();
            if (got.status !== want.status) begin
               report_mismatch($sformatf("status got %0d, expected %0d",
                                         got.status, want.status));
            end
            for (int k = 0; k < NoteKinds; k++) begin
               if (got.notes[k] !== want.notes[k]) begin
                  report_mismatch($sformatf("notes_%0d got %0d, expected %0d",
                                            gnd_pkg::NOTE_VALUE[k], got.notes[k],
                                            want.notes[k]));
               end
            end
         end
         checked_payouts++;
      end
   end

   // watchdog on cycles with no item taken on either side
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            stall_cycles <= 0;
         end else begin
            stall_cycles <= stall_cycles + 1;
         end
         if (stall_cycles >= StallLimit) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

endmodule
